@@ hw/rtl/adpi_pkg.sv @@
// types and constants for the aarch64 data-processing immediate unit
// no dependencies; imported by the unit and its checker
`timescale 1ns / 1ps

package adpi_pkg;

    // instruction class codes (bits 25:23)
    localparam logic [2:0] OPI_ARITH = 3'b010;
    localparam logic [2:0] OPI_WIDE  = 3'b101;

    // wide-move opc codes
    localparam logic [1:0] OPC_MOVN = 2'b00;
    localparam logic [1:0] OPC_MOVZ = 2'b10;
    localparam logic [1:0] OPC_MOVK = 2'b11;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LOW32    = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned TOP64    = 63;
    localparam int unsigned TOP32    = 31;

    // request: one instruction with its operands
    typedef struct packed {
        logic [31:0] instr_word;
        logic [63:0] src_value;
        logic [63:0] dest_old_value;
    } adpi_req_t;

    // result: destination write and flags
    typedef struct packed {
        logic [4:0]  dest_index;
        logic [63:0] write_value;
        logic        flags_write;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
    } adpi_res_t;

endpackage

@@ hw/rtl/aarch64_dp_immediate_unit.sv @@
// path: an accepted request is registered in stages 1, 2 and 3 before its result can be taken
// throughput: one request per cycle; a bubble in the pipe is filled even while
// the output is stalled, a full pipe holds every stage in place
// reset: rst_n asynchronous, active low, clears the stage valid bits only
// file holds the three-stage data-processing immediate unit
// depends on adpi_pkg
`timescale 1ns / 1ps

module aarch64_dp_immediate_unit
    import adpi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  adpi_req_t req_data,
    output logic      res_valid,
    input  logic      res_stall,
    output adpi_res_t res_data
);

    // stage 1: decoded operands
    typedef struct packed {
        logic [4:0]  rd;
        logic        wide;
        logic        arith;
        logic        sub;
        logic        setf;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] other;
    } s1_t;

    // stage 2: adder result
    typedef struct packed {
        logic [4:0]  rd;
        logic        wide;
        logic        setf;
        logic        a_top;
        logic        b_top;
        logic        carry;
        logic [63:0] value;
    } s2_t;

    logic      s1_valid_reg, s1_valid_next;
    logic      s2_valid_reg, s2_valid_next;
    logic      s3_valid_reg, s3_valid_next;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    adpi_res_t s3_reg, s3_next;
    logic      en1, en2, en3;

    // stage enables: a stage moves when it is empty or the one after it moves
    assign en3 = !s3_valid_reg || !res_stall;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign req_stall = !en1;

    assign s1_valid_next = req_valid;
    assign s2_valid_next = s1_valid_reg;
    assign s3_valid_next = s2_valid_reg;

    // stage 1 logic: decode, immediate, wide move
    always_comb
    begin
        logic [31:0] w;
        logic        wide;
        logic [1:0]  opc;
        logic [2:0]  opi;
        logic [63:0] mask;
        logic [5:0]  shamt;
        logic [63:0] op;
        logic [63:0] kmask;
        logic [63:0] cur;
        logic [63:0] mov;
        w     = req_data.instr_word;
        wide  = w[31];
        opc   = w[30:29];
        opi   = w[25:23];
        mask  = wide ? ALL_ONES : LOW32;
        shamt = {w[22:21], 4'b0000};
        op    = {48'b0, w[20:5]} << shamt;
        kmask = {48'b0, 16'hFFFF} << shamt;
        cur   = req_data.dest_old_value & mask;
        case (opc)
            OPC_MOVN: mov = ~op;
            OPC_MOVZ: mov = op;
            OPC_MOVK: mov = (cur & ~kmask) | op;
            default:  mov = cur;
        endcase
        s1_next.rd    = w[4:0];
        s1_next.wide  = wide;
        s1_next.arith = (opi == OPI_ARITH);
        s1_next.sub   = opc[1];
        s1_next.setf  = (opi == OPI_ARITH) && opc[0];
        s1_next.a     = req_data.src_value & mask;
        s1_next.b     = w[22] ? {40'b0, w[21:10], 12'b0} : {52'b0, w[21:10]};
        s1_next.other = (opi == OPI_WIDE) ? (mov & mask) : req_data.dest_old_value;
    end

    // stage 2 logic: add or subtract, select written value
    always_comb
    begin
        logic [63:0] bx;
        logic [64:0] sum;
        logic [32:0] lo;
        logic [63:0] mask;
        bx   = s1_reg.sub ? ~s1_reg.b : s1_reg.b;
        sum  = {1'b0, s1_reg.a} + {1'b0, bx} + {64'b0, s1_reg.sub};
        lo   = {1'b0, s1_reg.a[31:0]} + {1'b0, bx[31:0]} + {32'b0, s1_reg.sub};
        mask = s1_reg.wide ? ALL_ONES : LOW32;
        s2_next.rd    = s1_reg.rd;
        s2_next.wide  = s1_reg.wide;
        s2_next.setf  = s1_reg.setf;
        s2_next.a_top = s1_reg.wide ? s1_reg.a[TOP64] : s1_reg.a[TOP32];
        s2_next.b_top = s1_reg.wide ? bx[TOP64] : bx[TOP32];
        s2_next.carry = s1_reg.wide ? sum[64] : lo[32];
        s2_next.value = s1_reg.arith ? (sum[63:0] & mask) : s1_reg.other;
    end

    // stage 3 logic: flags at operating width
    always_comb
    begin
        logic r_top;
        logic zero;
        r_top = s2_reg.wide ? s2_reg.value[TOP64] : s2_reg.value[TOP32];
        zero  = s2_reg.wide ? (s2_reg.value == 64'b0) : (s2_reg.value[31:0] == 32'b0);
        s3_next.dest_index  = s2_reg.rd;
        s3_next.write_value = s2_reg.value;
        s3_next.flags_write = s2_reg.setf;
        s3_next.flag_n      = s2_reg.setf && r_top;
        s3_next.flag_z      = s2_reg.setf && zero;
        s3_next.flag_c      = s2_reg.setf && s2_reg.carry;
        s3_next.flag_v      = s2_reg.setf && (s2_reg.a_top == s2_reg.b_top)
                              && (r_top != s2_reg.a_top);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (en2)
            begin
                s2_valid_reg <= s2_valid_next;
            end
            if (en3)
            begin
                s3_valid_reg <= s3_valid_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign res_valid = s3_valid_reg;
    assign res_data  = s3_reg;

endmodule

@@ hw/rtl/adpi_checker.sv @@
// port-level checker for the data-processing immediate unit, with its bind
// depends on adpi_pkg and aarch64_dp_immediate_unit
`timescale 1ns / 1ps

module adpi_checker
    import adpi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input adpi_req_t req_data,
    input logic      res_valid,
    input logic      res_stall,
    input adpi_res_t res_data
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // no request stall while the output can drain
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid || !res_stall |-> !req_stall)
        else $error("request stalled with a free output");

    // flags stay clear when not written
    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.flags_write |->
            !res_data.flag_n && !res_data.flag_z && !res_data.flag_c && !res_data.flag_v)
        else $error("flags set without flag write");

    // zero result cannot be negative
    a_z_not_n: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.flag_z |-> !res_data.flag_n)
        else $error("n and z both set");

    // a stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
        else $error("stalled request changed");

endmodule

bind aarch64_dp_immediate_unit adpi_checker u_adpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

@@ sim/tb.sv @@
// self-checking bench for aarch64_dp_immediate_unit: directed and random instructions
// with a built-in predictor, random gaps on requests and random stalls on results
// depends on adpi_pkg and the unit rtl
`timescale 1ns / 1ps

module tb
    import adpi_pkg::*;
();

    // add/sub opc codes and the wide-move code left unallocated
    localparam logic [1:0] OPC_ADD     = 2'b00;
    localparam logic [1:0] OPC_ADDS    = 2'b01;
    localparam logic [1:0] OPC_SUB     = 2'b10;
    localparam logic [1:0] OPC_SUBS    = 2'b11;
    localparam logic [1:0] OPC_UNALLOC = 2'b01;

    localparam int RANDOM_ITEMS    = 1200;
    localparam int MAX_SHOWN       = 10;
    localparam int DRAIN_CYCLES    = 12;
    localparam int WATCHDOG_CYCLES = 2000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    adpi_req_t req_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    adpi_res_t res_data;

    adpi_req_t instr_queue[$];
    adpi_res_t due_results[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    logic      started = 1'b0;
    logic      req_taken = 1'b0;
    logic      res_taken = 1'b0;
    int        req_gap = 0;
    int        res_hold = 0;
    logic      req_burst = 1'b0;
    logic      res_burst = 1'b0;

    aarch64_dp_immediate_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // expected destination write and flags for one instruction
    function automatic adpi_res_t exec_dp_imm(adpi_req_t r);
        logic [31:0] w;
        logic        is64;
        logic [1:0]  opc;
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] imm;
        logic [63:0] sum;
        logic [63:0] ovf;
        logic [64:0] full;
        logic [63:0] field;
        logic [63:0] keep;
        int unsigned top;
        int unsigned shift;
        adpi_res_t   o;
        w    = r.instr_word;
        is64 = w[31];
        opc  = w[30:29];
        mask = is64 ? ALL_ONES : LOW32;
        top  = is64 ? TOP64 : TOP32;
        o    = '0;
        o.dest_index  = w[4:0];
        o.write_value = r.dest_old_value;
        // add/sub with optionally shifted 12-bit immediate
        if (w[25:23] == OPI_ARITH)
        begin
            a   = r.src_value & mask;
            imm = {52'd0, w[21:10]};
            if (w[22])
                imm = imm << 12;
            full = opc[1] ? ({1'b0, a} - {1'b0, imm}) : ({1'b0, a} + {1'b0, imm});
            sum  = full[63:0] & mask;
            o.write_value = sum;
            if (opc[0])
            begin
                o.flags_write = 1'b1;
                o.flag_n = sum[top];
                o.flag_z = (sum == 64'd0);
                if (opc[1])
                begin
                    o.flag_c = (a >= imm);
                    ovf = (a ^ imm) & (a ^ sum);
                end
                else
                begin
                    o.flag_c = is64 ? full[64] : full[32];
                    ovf = (a ^ sum) & (imm ^ sum);
                end
                o.flag_v = ovf[top];
            end
        end
        // wide moves, halfword placed at hw*16 before the width mask
        else if (w[25:23] == OPI_WIDE)
        begin
            shift = {26'd0, w[22:21], 4'd0};
            field = {48'd0, w[20:5]} << shift;
            keep  = r.dest_old_value & mask;
            case (opc)
                OPC_MOVN: o.write_value = ~field & mask;
                OPC_MOVZ: o.write_value = field & mask;
                OPC_MOVK: o.write_value = ((keep & ~(64'hFFFF << shift)) | field) & mask;
                default:  o.write_value = keep;
            endcase
        end
        return o;
    endfunction

    // instruction encoders, op0 bits filled at random since they are not decoded
    function automatic logic [31:0] arith_word(logic sf, logic [1:0] opc, logic sh,
                                               logic [11:0] imm12, logic [4:0] rn,
                                               logic [4:0] rd);
        logic [2:0] op0;
        op0 = 3'($urandom);
        return {sf, opc, op0, OPI_ARITH, sh, imm12, rn, rd};
    endfunction

    function automatic logic [31:0] wide_word(logic sf, logic [1:0] opc, logic [1:0] hw,
                                              logic [15:0] imm16, logic [4:0] rd);
        logic [2:0] op0;
        op0 = 3'($urandom);
        return {sf, opc, op0, OPI_WIDE, hw, imm16, rd};
    endfunction

    function automatic void queue_instr(logic [31:0] w, logic [63:0] src, logic [63:0] old);
        adpi_req_t r;
        r.instr_word     = w;
        r.src_value      = src;
        r.dest_old_value = old;
        instr_queue.push_back(r);
    endfunction

    // operand values biased towards carry, borrow and sign boundaries
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 12))
            0:       return 64'd0;
            1:       return ALL_ONES;
            2:       return 64'h7FFF_FFFF_FFFF_FFFF;
            3:       return 64'h8000_0000_0000_0000;
            4:       return ALL_ONES - 64'($urandom_range(0, 24'hFFFFFF));
            5:       return {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 24'hFFFFFF)};
            6:       return {$urandom, 32'h0000_0000 + $urandom_range(0, 24'hFFFFFF)};
            7:       return {$urandom, 32'h7FFF_FFFF - $urandom_range(0, 24'hFFFFFF)};
            8:       return {$urandom, 32'h8000_0000 + $urandom_range(0, 24'hFFFFFF)};
            9:       return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 24'hFFFFFF));
            10:      return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 24'hFFFFFF));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // request driver: next instruction after the drawn gap, held while stalled
    always @(negedge clk)
    begin
        if (started && !(req_valid && !req_taken))
        begin
            if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap   <= req_gap - 1;
            end
            else if (instr_queue.size() > 0)
            begin
                req_data  <= instr_queue.pop_front();
                req_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    req_burst <= !req_burst;
                req_gap <= req_burst ? 0 : $urandom_range(0, 5);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result stall: a drawn number of stall cycles after each taken result
    always @(negedge clk)
    begin : res_side
        int n;
        if (res_taken)
        begin
            if ($urandom_range(0, 39) == 0)
                res_burst <= !res_burst;
            n = res_burst ? 0 : $urandom_range(0, 5);
            res_hold  <= n;
            res_stall <= (n > 0);
        end
        else if (res_hold > 0)
        begin
            res_hold  <= res_hold - 1;
            res_stall <= (res_hold > 1);
        end
        else
            res_stall <= 1'b0;
    end

    // monitor: predict on every taken request, check every taken result
    always @(posedge clk)
    begin : monitor
        adpi_res_t want;
        started   <= rst_n;
        req_taken <= req_valid && !req_stall;
        res_taken <= res_valid && !res_stall;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                due_results.push_back(exec_dp_imm(req_data));
            if (res_valid && !res_stall)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: rd=%0d val=%h", res_data.dest_index,
                                 res_data.write_value);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res_data.dest_index !== want.dest_index ||
                        res_data.write_value !== want.write_value ||
                        res_data.flags_write !== want.flags_write ||
                        res_data.flag_n !== want.flag_n || res_data.flag_z !== want.flag_z ||
                        res_data.flag_c !== want.flag_c || res_data.flag_v !== want.flag_v)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $display("mismatch: want rd=%0d val=%h fw=%b nzcv=%b%b%b%b",
                                     want.dest_index, want.write_value, want.flags_write,
                                     want.flag_n, want.flag_z, want.flag_c, want.flag_v);
                            $display("          got  rd=%0d val=%h fw=%b nzcv=%b%b%b%b",
                                     res_data.dest_index, res_data.write_value,
                                     res_data.flags_write, res_data.flag_n,
                                     res_data.flag_z, res_data.flag_c, res_data.flag_v);
                        end
                    end
                end
            end
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] word;
        logic [11:0] imm12;
        logic [15:0] imm16;
        logic [2:0]  opi;
        int          kind;

        // add/sub: wrap, carry, overflow and zero at both widths
        queue_instr(arith_word(1'b1, OPC_ADD, 1'b0, 12'hFFF, 5'd1, 5'd0), ALL_ONES, 64'd0);
        queue_instr(arith_word(1'b1, OPC_ADDS, 1'b1, 12'hFFF, 5'd2, 5'd31),
                    64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES);
        queue_instr(arith_word(1'b1, OPC_ADDS, 1'b0, 12'h001, 5'd3, 5'd1), ALL_ONES, 64'd0);
        queue_instr(arith_word(1'b1, OPC_SUBS, 1'b0, 12'h000, 5'd4, 5'd2), 64'd0, ALL_ONES);
        queue_instr(arith_word(1'b1, OPC_SUBS, 1'b0, 12'h001, 5'd5, 5'd3), 64'd0, 64'd0);
        queue_instr(arith_word(1'b1, OPC_SUBS, 1'b0, 12'h001, 5'd6, 5'd4),
                    64'h8000_0000_0000_0000, 64'd0);
        queue_instr(arith_word(1'b1, OPC_SUB, 1'b1, 12'hABC, 5'd7, 5'd5),
                    64'h0000_0000_00AB_C000, 64'd0);
        queue_instr(arith_word(1'b0, OPC_ADDS, 1'b0, 12'h001, 5'd8, 5'd6),
                    64'hDEAD_BEEF_FFFF_FFFF, ALL_ONES);
        queue_instr(arith_word(1'b0, OPC_ADDS, 1'b1, 12'h001, 5'd9, 5'd7),
                    64'h1234_5678_7FFF_F000, 64'd0);
        queue_instr(arith_word(1'b0, OPC_SUBS, 1'b0, 12'h001, 5'd10, 5'd8),
                    64'hFFFF_FFFF_8000_0000, 64'd0);
        queue_instr(arith_word(1'b0, OPC_SUBS, 1'b1, 12'hFFF, 5'd11, 5'd9),
                    64'h0000_0001_00FF_F000, 64'd0);
        queue_instr(arith_word(1'b0, OPC_ADD, 1'b1, 12'hFFF, 5'd13, 5'd11), ALL_ONES,
                    ALL_ONES);

        // wide moves at every halfword position; 32-bit movn covers the high hw case
        for (int hw = 0; hw < 4; hw++)
        begin
            queue_instr(wide_word(1'b1, OPC_MOVK, 2'(hw), 16'h8001, 5'd12), ALL_ONES,
                        64'h0123_4567_89AB_CDEF);
            queue_instr(wide_word(1'b0, OPC_MOVN, 2'(hw), 16'h0000, 5'd14), 64'd0, ALL_ONES);
        end
        queue_instr(wide_word(1'b1, OPC_MOVZ, 2'd3, 16'hFFFF, 5'd15), 64'd0, ALL_ONES);
        queue_instr(wide_word(1'b0, OPC_MOVZ, 2'd2, 16'hFFFF, 5'd16), 64'd0, ALL_ONES);
        queue_instr(wide_word(1'b0, OPC_MOVK, 2'd3, 16'hFFFF, 5'd17), 64'd0,
                    64'hFEDC_BA98_7654_3210);

        // unallocated wide-move opc, then words of other classes that are ignored
        queue_instr(wide_word(1'b1, OPC_UNALLOC, 2'd1, 16'h5A5A, 5'd18), 64'd0,
                    64'hCAFE_F00D_1234_5678);
        queue_instr(wide_word(1'b0, OPC_UNALLOC, 2'd0, 16'hA5A5, 5'd19), 64'd0,
                    64'hCAFE_F00D_1234_5678);
        queue_instr(32'h0000_0000, ALL_ONES, 64'h1122_3344_5566_7788);
        queue_instr(32'hFFFF_FFFF, 64'd0, ALL_ONES);

        // random mix: mostly well-formed instructions, some other classes and noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind  = $urandom_range(0, 9);
            imm12 = 12'($urandom);
            imm16 = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
                imm12 = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            if ($urandom_range(0, 3) == 0)
                imm16 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            if (kind < 4)
                word = arith_word(1'($urandom), 2'($urandom), 1'($urandom), imm12,
                                  5'($urandom), 5'($urandom));
            else if (kind < 8)
                word = wide_word(1'($urandom), 2'($urandom), 2'($urandom), imm16,
                                 5'($urandom));
            else if (kind == 8)
            begin
                word = $urandom;
                do
                    opi = 3'($urandom);
                while (opi == OPI_ARITH || opi == OPI_WIDE);
                word[25:23] = opi;
            end
            else
                word = $urandom;
            queue_instr(word, pick_operand(), pick_operand());
        end

        // hold reset, then release it away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: all requests sent and all results back, then a quiet wait before the verdict
        while (instr_queue.size() != 0 || req_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
